### design/vmp_pkg.sv
// shared types and constants of the 2x2x2 mean-pool downsampler
`default_nettype none

package vmp_pkg;

  // sample and result widths
  localparam int SAMPLE_W = 16;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int QUAD_W   = SAMPLE_W + 2;
  localparam int TOTAL_W  = SAMPLE_W + 3;

  // configuration register widths and reset values
  localparam int VOL_WIDTH_W  = 10;
  localparam int VOL_HEIGHT_W = 10;
  localparam int VOL_DEPTH_W  = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [VOL_WIDTH_W-1:0]  VOL_WIDTH_RST  = 10'd512;
  localparam logic [VOL_HEIGHT_W-1:0] VOL_HEIGHT_RST = 10'd512;
  localparam logic [VOL_DEPTH_W-1:0]  VOL_DEPTH_RST  = 13'd4096;

  // smallest usable dimension
  localparam int MIN_DIM = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_VOL_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VOL_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VOL_DEPTH  = 2'd2;

  // position flags of the voxel at the input
  typedef struct packed {
    logic pair_lo;   // even column inside the pooled region
    logic pair_hi;   // odd column inside the pooled region
    logic row_odd;   // odd row
    logic plane_odd; // odd plane
    logic last;      // completes the final cube of the volume
  } pos_flags_t;

endpackage

`default_nettype wire

### design/volume_mean_pool_2x2x2_core.sv
// top level of the streaming 2x2x2 mean-pool volume downsampler
`default_nettype none

// Takes one source voxel per transaction in raster order (plane, row, column)
// and returns one voxel per 2x2x2 cube, the floor of the cube sum over eight;
// a trailing odd column, row or plane is consumed and dropped. The core takes
// one voxel every cycle unless a stalled output holds stage b; the plane store
// is a memory with one write and one registered read port that is touched once
// per completed 2x2 sum. A result is registered in stage b and then in the
// output register, and tlast marks the final result of the volume. The row
// store holds MAX_WIDTH/2 pair sums and the plane store
// (MAX_WIDTH/2)*(MAX_HEIGHT/2) 2x2 sums; neither needs clearing after reset,
// since raster order writes every entry before it is read. Writing any
// register restarts the volume at its first voxel; write only while idle.
module volume_mean_pool_2x2x2_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_DEPTH  = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [vmp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [vmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // source voxels
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [15:0]                    in_tdata,   // [15:0] sample
  // pooled voxels
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [15:0]                    out_tdata,  // [15:0] mean
  output logic                                out_tlast   // last_of_volume
);

  import vmp_pkg::*;

  localparam int HALF_W = MAX_WIDTH / 2;
  localparam int QUADS  = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int XW     = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int QW     = (QUADS > 1) ? $clog2(QUADS) : 1;

  pos_flags_t flags;
  logic [XW-1:0] x_addr;
  logic [QW-1:0] quad_idx;

  logic                in_fire, adv_b;
  logic [SAMPLE_W-1:0] pair_sum_r;
  logic [PAIR_W-1:0]   pair;
  logic                row_we, row_re, plane_we, plane_re;
  logic [PAIR_W-1:0]   row_rd;
  logic [QUAD_W-1:0]   plane_rd, quad;
  logic [TOTAL_W-1:0]  total;

  logic              b_valid_r, b_emit_r, b_last_r;
  logic [PAIR_W-1:0] b_pair_r;
  logic [QW-1:0]     b_idx_r;

  logic                out_valid_r, out_last_r;
  logic [SAMPLE_W-1:0] out_mean_r;

  // position tracking
  vmp_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .XW         (XW),
    .QW         (QW)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (in_fire),
    .flags     (flags),
    .x_addr    (x_addr),
    .quad_idx  (quad_idx)
  );

  // handshake: stage b moves when the output register frees up
  assign adv_b     = !out_valid_r || out_tready;
  assign in_tready = !b_valid_r || adv_b;
  assign in_fire   = in_tvalid && in_tready;

  // horizontal pair
  assign pair = {1'b0, pair_sum_r} + {1'b0, in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_sum_r <= '0;
    end else if (in_fire && flags.pair_lo) begin
      pair_sum_r <= in_tdata;
    end
  end

  // row store: even rows write pair sums, odd rows read them back
  assign row_we = in_fire && flags.pair_hi && !flags.row_odd;
  assign row_re = in_fire && flags.pair_hi && flags.row_odd;

  vmp_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (HALF_W),
    .AW    (XW)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (x_addr),
    .wr_data (pair),
    .rd_en   (row_re),
    .rd_addr (x_addr),
    .rd_data (row_rd)
  );

  // stage b: items that complete a 2x2 sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_tready) begin
      b_valid_r <= in_fire && flags.pair_hi && flags.row_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_pair_r <= pair;
      b_idx_r  <= quad_idx;
      b_emit_r <= flags.plane_odd;
      b_last_r <= flags.last;
    end
  end

  assign quad = {1'b0, row_rd} + {1'b0, b_pair_r};

  // plane store: even planes write 2x2 sums, odd planes read them back
  assign plane_re = row_re && flags.plane_odd;
  assign plane_we = b_valid_r && adv_b && !b_emit_r;

  vmp_ram #(
    .WIDTH (QUAD_W),
    .DEPTH (QUADS),
    .AW    (QW)
  ) u_plane_store (
    .clk     (clk),
    .wr_en   (plane_we),
    .wr_addr (b_idx_r),
    .wr_data (quad),
    .rd_en   (plane_re),
    .rd_addr (quad_idx),
    .rd_data (plane_rd)
  );

  assign total = {1'b0, plane_rd} + {1'b0, quad};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_b) begin
      out_valid_r <= b_valid_r && b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      out_mean_r <= total[TOTAL_W-1:3];
      out_last_r <= b_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mean_r;
  assign out_tlast  = out_last_r;

  // row store is never read and written in the same cycle
  a_row_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(row_we && row_re))
    else $error("row store read and write collide");

  // a read of the plane store never hits the entry being written
  a_plane_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (plane_we && plane_re) |-> (b_idx_r != quad_idx))
    else $error("plane store read hits entry under write");

  // a new result only comes from an odd-plane item in stage b
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_valid_r && b_emit_r))
    else $error("result without an odd-plane cube");

  // a stalled stage b blocks the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && out_valid_r && !out_tready) |=> $stable(b_pair_r))
    else $error("stage b payload changed while stalled");

endmodule

`default_nettype wire

### design/vmp_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module vmp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/vmp_pos.sv
// configuration registers, raster position counters and store addresses
`default_nettype none

module vmp_pos #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_DEPTH  = 4096,
  parameter int XW = ((MAX_WIDTH / 2) > 1) ? $clog2(MAX_WIDTH / 2) : 1,
  parameter int QW = (((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)) > 1) ?
                     $clog2((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [vmp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [vmp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            accept,
  output vmp_pkg::pos_flags_t                  flags,
  output logic      [XW-1:0]                   x_addr,
  output logic      [QW-1:0]                   quad_idx
);

  import vmp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = $clog2(MAX_DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [VOL_WIDTH_W-1:0]  vol_width_r;
  logic [VOL_HEIGHT_W-1:0] vol_height_r;
  logic [VOL_DEPTH_W-1:0]  vol_depth_r;

  logic [CW-1:0] col_r,   col_nxt;
  logic [RW-1:0] row_r,   row_nxt;
  logic [PW-1:0] plane_r, plane_nxt;
  logic [QW-1:0] qidx_r,  qidx_nxt;

  logic [31:0]   w32, h32, d32;
  logic [WW-1:0] w_eff, w_even;
  logic [HW-1:0] h_eff, h_even;
  logic [DW-1:0] d_eff, d_even;
  logic          col_last, row_last, plane_last;
  logic          in_region, quad_item, cfg_hit;

  // clamp the registers into the usable range
  always_comb begin
    if (32'(vol_width_r) < MIN_DIM) w32 = MIN_DIM;
    else if (32'(vol_width_r) > MAX_WIDTH) w32 = MAX_WIDTH;
    else w32 = 32'(vol_width_r);
    if (32'(vol_height_r) < MIN_DIM) h32 = MIN_DIM;
    else if (32'(vol_height_r) > MAX_HEIGHT) h32 = MAX_HEIGHT;
    else h32 = 32'(vol_height_r);
    if (32'(vol_depth_r) < MIN_DIM) d32 = MIN_DIM;
    else if (32'(vol_depth_r) > MAX_DEPTH) d32 = MAX_DEPTH;
    else d32 = 32'(vol_depth_r);
  end

  assign w_eff  = WW'(w32);
  assign h_eff  = HW'(h32);
  assign d_eff  = DW'(d32);
  assign w_even = {w_eff[WW-1:1], 1'b0};
  assign h_even = {h_eff[HW-1:1], 1'b0};
  assign d_even = {d_eff[DW-1:1], 1'b0};

  // position decode
  assign col_last   = (WW'(col_r) == w_eff - WW'(1));
  assign row_last   = (HW'(row_r) == h_eff - HW'(1));
  assign plane_last = (DW'(plane_r) == d_eff - DW'(1));
  assign in_region  = (WW'(col_r) < w_even) && (HW'(row_r) < h_even) &&
                      (DW'(plane_r) < d_even);
  assign quad_item  = in_region && col_r[0] && row_r[0];

  always_comb begin
    flags.pair_lo   = in_region && !col_r[0];
    flags.pair_hi   = in_region && col_r[0];
    flags.row_odd   = row_r[0];
    flags.plane_odd = plane_r[0];
    flags.last      = (DW'(plane_r) == d_even - DW'(1)) &&
                      (HW'(row_r) == h_even - HW'(1)) &&
                      (WW'(col_r) == w_even - WW'(1));
  end

  assign x_addr   = XW'(col_r >> 1);
  assign quad_idx = qidx_r;

  // a write to a listed register restarts the volume
  always_comb begin
    unique case (cfg_addr)
      REG_VOL_WIDTH, REG_VOL_HEIGHT, REG_VOL_DEPTH: cfg_hit = cfg_we;
      default:                                      cfg_hit = 1'b0;
    endcase
  end

  // next position
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    qidx_nxt  = qidx_r;
    priority if (cfg_hit) begin
      col_nxt   = '0;
      row_nxt   = '0;
      plane_nxt = '0;
      qidx_nxt  = '0;
    end else if (accept) begin
      if (quad_item) qidx_nxt = qidx_r + QW'(1);
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          qidx_nxt = '0;
          plane_nxt = plane_last ? '0 : plane_r + PW'(1);
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // position and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_width_r  <= VOL_WIDTH_RST;
      vol_height_r <= VOL_HEIGHT_RST;
      vol_depth_r  <= VOL_DEPTH_RST;
      col_r        <= '0;
      row_r        <= '0;
      plane_r      <= '0;
      qidx_r       <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      qidx_r  <= qidx_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_VOL_WIDTH:  vol_width_r  <= cfg_wdata[VOL_WIDTH_W-1:0];
          REG_VOL_HEIGHT: vol_height_r <= cfg_wdata[VOL_HEIGHT_W-1:0];
          REG_VOL_DEPTH:  vol_depth_r  <= cfg_wdata[VOL_DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
